// File: rtl/fmrq_pkg.sv
// ----------------------------------------------------------------------------
// fmrq_pkg
// Shared types and constants of the framed message ring queue.
// ----------------------------------------------------------------------------
`default_nettype none

package fmrq_pkg;

  // Ring geometry; the depth must be a power of two so the pointers wrap.
  localparam int RING_DEPTH  = 256;
  localparam int MAX_PAYLOAD = 32;
  localparam int WORD_BITS   = 32;
  localparam int PTR_W       = $clog2(RING_DEPTH);

  // Field widths of the channels
  localparam int ACT_W  = 2;
  localparam int ID_W   = 32;
  localparam int LEN_W  = 6;
  localparam int DATA_W = 32;
  localparam int STS_W  = 2;
  localparam int KIND_W = 2;

  // Width used for the free room test
  localparam int ROOM_W = (PTR_W + 1 > LEN_W + 1) ? PTR_W + 1 : LEN_W + 1;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUT_HDR  = 2'd0,
    ACT_PUT_WORD = 2'd1,
    ACT_GET      = 2'd2,
    ACT_FLUSH    = 2'd3
  } action_e;

  typedef enum logic [STS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_TOO_LONG = 2'd2,
    ST_NO_ROOM  = 2'd3
  } status_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACK  = 2'd0,
    KIND_HDR  = 2'd1,
    KIND_WORD = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_HDR_LEN,
    S_GET_LEN,
    S_GET_HDR,
    S_STREAM
  } state_e;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_HDR_ABORT,
    OP_HDR_ID,
    OP_HDR_LEN,
    OP_PAYLOAD,
    OP_FLUSH,
    OP_RD_ID,
    OP_RD_LEN,
    OP_RD_HDR,
    OP_RD_WORD
  } dp_op_e;

  typedef struct packed {
    logic    in_load;
    dp_op_e  op;
    logic    out_load;
    kind_e   out_kind;
    status_e ack_status;
  } cmd_t;

  typedef struct packed {
    action_e action;
    logic    too_long;
    logic    no_room;
    logic    empty;
    logic    rem_zero;
    logic    hdr_len_zero;
    logic    cnt_one;
    logic    out_free;
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/fmrq_in_if.sv
// ----------------------------------------------------------------------------
// fmrq_in_if
// Request channel: action and operands, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface fmrq_in_if;
  logic                         valid;
  logic                         ready;
  logic [fmrq_pkg::ACT_W-1:0]   action;
  logic [fmrq_pkg::ID_W-1:0]    msg_id;
  logic [fmrq_pkg::LEN_W-1:0]   msg_len;
  logic [fmrq_pkg::DATA_W-1:0]  data_word;

  modport source (output valid, action, msg_id, msg_len, data_word, input ready);
  modport sink   (input valid, action, msg_id, msg_len, data_word, output ready);
endinterface

`default_nettype wire

// File: rtl/fmrq_out_if.sv
// ----------------------------------------------------------------------------
// fmrq_out_if
// Result channel: status, kind and read words, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface fmrq_out_if;
  logic                         valid;
  logic                         ready;
  logic [fmrq_pkg::STS_W-1:0]   status;
  logic [fmrq_pkg::KIND_W-1:0]  kind;
  logic [fmrq_pkg::ID_W-1:0]    out_id;
  logic [fmrq_pkg::LEN_W-1:0]   out_len;
  logic [fmrq_pkg::DATA_W-1:0]  out_word;
  logic                         last;

  modport source (output valid, status, kind, out_id, out_len, out_word, last,
                  input ready);
  modport sink   (input valid, status, kind, out_id, out_len, out_word, last,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/fmrq_ctrl.sv
// ----------------------------------------------------------------------------
// fmrq_ctrl
// Sequencer: takes one request at a time and steps the datapath through it.
// ----------------------------------------------------------------------------
`default_nettype none

module fmrq_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire fmrq_pkg::sts_t sts_i,
  output fmrq_pkg::cmd_t      cmd_o
);

  fmrq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fmrq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fmrq_pkg::S_IDLE: begin
        if (in_valid_i) state_d = fmrq_pkg::S_EXEC;
      end
      fmrq_pkg::S_EXEC: begin
        if (sts_i.out_free) begin
          state_d = fmrq_pkg::S_IDLE;
          if (sts_i.action == fmrq_pkg::ACT_PUT_HDR && !sts_i.too_long &&
              !sts_i.no_room) begin
            state_d = fmrq_pkg::S_HDR_LEN;
          end else if (sts_i.action == fmrq_pkg::ACT_GET && !sts_i.empty) begin
            state_d = fmrq_pkg::S_GET_LEN;
          end
        end
      end
      fmrq_pkg::S_HDR_LEN: state_d = fmrq_pkg::S_IDLE;
      fmrq_pkg::S_GET_LEN: state_d = fmrq_pkg::S_GET_HDR;
      fmrq_pkg::S_GET_HDR: begin
        if (sts_i.out_free) begin
          state_d = sts_i.hdr_len_zero ? fmrq_pkg::S_IDLE : fmrq_pkg::S_STREAM;
        end
      end
      fmrq_pkg::S_STREAM: begin
        if (sts_i.out_free && sts_i.cnt_one) state_d = fmrq_pkg::S_IDLE;
      end
      default: state_d = fmrq_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o        = 1'b0;
    cmd_o.in_load     = 1'b0;
    cmd_o.op          = fmrq_pkg::OP_NONE;
    cmd_o.out_load    = 1'b0;
    cmd_o.out_kind    = fmrq_pkg::KIND_ACK;
    cmd_o.ack_status  = fmrq_pkg::ST_OK;
    case (state_q)
      fmrq_pkg::S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.in_load = in_valid_i;
      end
      fmrq_pkg::S_EXEC: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          case (sts_i.action)
            fmrq_pkg::ACT_PUT_HDR: begin
              if (sts_i.too_long) begin
                cmd_o.op         = fmrq_pkg::OP_HDR_ABORT;
                cmd_o.ack_status = fmrq_pkg::ST_TOO_LONG;
              end else if (sts_i.no_room) begin
                cmd_o.op         = fmrq_pkg::OP_HDR_ABORT;
                cmd_o.ack_status = fmrq_pkg::ST_NO_ROOM;
              end else begin
                cmd_o.op = fmrq_pkg::OP_HDR_ID;
              end
            end
            fmrq_pkg::ACT_PUT_WORD: begin
              cmd_o.op = fmrq_pkg::OP_PAYLOAD;
              if (sts_i.rem_zero) cmd_o.ack_status = fmrq_pkg::ST_NO_ROOM;
            end
            fmrq_pkg::ACT_GET: begin
              if (sts_i.empty) begin
                cmd_o.ack_status = fmrq_pkg::ST_EMPTY;
              end else begin
                cmd_o.op       = fmrq_pkg::OP_RD_ID;
                cmd_o.out_load = 1'b0;
              end
            end
            fmrq_pkg::ACT_FLUSH: cmd_o.op = fmrq_pkg::OP_FLUSH;
            default:             cmd_o.op = fmrq_pkg::OP_NONE;
          endcase
        end
      end
      fmrq_pkg::S_HDR_LEN: cmd_o.op = fmrq_pkg::OP_HDR_LEN;
      fmrq_pkg::S_GET_LEN: cmd_o.op = fmrq_pkg::OP_RD_LEN;
      fmrq_pkg::S_GET_HDR: begin
        if (sts_i.out_free) begin
          cmd_o.op       = fmrq_pkg::OP_RD_HDR;
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = fmrq_pkg::KIND_HDR;
        end
      end
      fmrq_pkg::S_STREAM: begin
        if (sts_i.out_free) begin
          cmd_o.op       = fmrq_pkg::OP_RD_WORD;
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = fmrq_pkg::KIND_WORD;
        end
      end
      default: cmd_o.op = fmrq_pkg::OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/fmrq_dpath.sv
// ----------------------------------------------------------------------------
// fmrq_dpath
// Ring memory, pointers, counters and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fmrq_dpath (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire fmrq_pkg::cmd_t               cmd_i,
  output fmrq_pkg::sts_t                    sts_o,
  input  wire logic [fmrq_pkg::ACT_W-1:0]   action_i,
  input  wire logic [fmrq_pkg::ID_W-1:0]    msg_id_i,
  input  wire logic [fmrq_pkg::LEN_W-1:0]   msg_len_i,
  input  wire logic [fmrq_pkg::DATA_W-1:0]  data_word_i,
  input  wire logic                         out_ready_i,
  output logic                              out_valid_o,
  output logic [fmrq_pkg::STS_W-1:0]        status_o,
  output logic [fmrq_pkg::KIND_W-1:0]       kind_o,
  output logic [fmrq_pkg::ID_W-1:0]         out_id_o,
  output logic [fmrq_pkg::LEN_W-1:0]        out_len_o,
  output logic [fmrq_pkg::DATA_W-1:0]       out_word_o,
  output logic                              last_o
);

  localparam int PW = fmrq_pkg::PTR_W;
  localparam int LW = fmrq_pkg::LEN_W;
  localparam int WW = fmrq_pkg::WORD_BITS;
  localparam int RW = fmrq_pkg::ROOM_W;

  // ring store, no reset: only committed words are ever read
  logic [WW-1:0] ring_q [fmrq_pkg::RING_DEPTH];
  logic [WW-1:0] rd_data_q;

  // latched request
  fmrq_pkg::action_e act_q;
  logic [fmrq_pkg::ID_W-1:0]   id_q;
  logic [LW-1:0]               len_q;
  logic [fmrq_pkg::DATA_W-1:0] data_q;

  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] fill_ptr_q, fill_ptr_d;
  logic [LW-1:0] rem_q, rem_d;
  logic [LW-1:0] cnt_q, cnt_d;
  logic [WW-1:0] hid_q, hid_d;

  logic          we;
  logic [PW-1:0] waddr;
  logic [WW-1:0] wdata;
  logic          re;

  logic          out_valid_q;
  fmrq_pkg::status_e out_sts_q;
  fmrq_pkg::kind_e   out_kind_q;
  logic [fmrq_pkg::ID_W-1:0]   out_id_q;
  logic [LW-1:0]               out_len_q;
  logic [fmrq_pkg::DATA_W-1:0] out_word_q;
  logic                        out_last_q;

  logic [PW-1:0] used;
  logic [RW-1:0] room;
  logic [RW-1:0] need;
  logic [LW-1:0] rd_len;
  logic          out_free;

  // free room test, strict so a full ring never reads as empty
  assign used = wr_ptr_q - rd_ptr_q;
  assign room = RW'(fmrq_pkg::RING_DEPTH) - RW'(used);
  assign need = RW'(len_q) + RW'(2);

  // stored length clamped on read
  assign rd_len = (rd_data_q > WW'(fmrq_pkg::MAX_PAYLOAD)) ?
                  LW'(fmrq_pkg::MAX_PAYLOAD) : LW'(rd_data_q);

  assign out_free = !out_valid_q || out_ready_i;

  assign sts_o.action       = act_q;
  assign sts_o.too_long     = len_q > LW'(fmrq_pkg::MAX_PAYLOAD);
  assign sts_o.no_room      = room <= need;
  assign sts_o.empty        = rd_ptr_q == wr_ptr_q;
  assign sts_o.rem_zero     = rem_q == '0;
  assign sts_o.hdr_len_zero = rd_len == '0;
  assign sts_o.cnt_one      = cnt_q == LW'(1);
  assign sts_o.out_free     = out_free;

  always_comb begin
    rd_ptr_d   = rd_ptr_q;
    wr_ptr_d   = wr_ptr_q;
    fill_ptr_d = fill_ptr_q;
    rem_d      = rem_q;
    cnt_d      = cnt_q;
    hid_d      = hid_q;
    we         = 1'b0;
    waddr      = fill_ptr_q;
    wdata      = WW'(data_q);
    re         = 1'b0;
    case (cmd_i.op)
      fmrq_pkg::OP_HDR_ABORT: begin
        fill_ptr_d = wr_ptr_q;
        rem_d      = '0;
      end
      fmrq_pkg::OP_HDR_ID: begin
        we         = 1'b1;
        waddr      = wr_ptr_q;
        wdata      = WW'(id_q);
        fill_ptr_d = wr_ptr_q + PW'(1);
        rem_d      = '0;
      end
      fmrq_pkg::OP_HDR_LEN: begin
        we         = 1'b1;
        wdata      = WW'(len_q);
        fill_ptr_d = fill_ptr_q + PW'(1);
        if (len_q == '0) begin
          wr_ptr_d = fill_ptr_q + PW'(1);
        end else begin
          rem_d = len_q;
        end
      end
      fmrq_pkg::OP_PAYLOAD: begin
        if (rem_q != '0) begin
          we         = 1'b1;
          fill_ptr_d = fill_ptr_q + PW'(1);
          rem_d      = rem_q - LW'(1);
          if (rem_q == LW'(1)) wr_ptr_d = fill_ptr_q + PW'(1);
        end
      end
      fmrq_pkg::OP_FLUSH: rd_ptr_d = wr_ptr_q;
      fmrq_pkg::OP_RD_ID: begin
        re       = 1'b1;
        rd_ptr_d = rd_ptr_q + PW'(1);
      end
      fmrq_pkg::OP_RD_LEN: begin
        hid_d    = rd_data_q;
        re       = 1'b1;
        rd_ptr_d = rd_ptr_q + PW'(1);
      end
      fmrq_pkg::OP_RD_HDR: begin
        cnt_d = rd_len;
        if (rd_len != '0) begin
          re       = 1'b1;
          rd_ptr_d = rd_ptr_q + PW'(1);
        end
      end
      fmrq_pkg::OP_RD_WORD: begin
        cnt_d = cnt_q - LW'(1);
        if (cnt_q != LW'(1)) begin
          re       = 1'b1;
          rd_ptr_d = rd_ptr_q + PW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) ring_q[waddr] <= wdata;
    if (re) rd_data_q <= ring_q[rd_ptr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      fill_ptr_q  <= '0;
      rem_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rd_ptr_q   <= rd_ptr_d;
      wr_ptr_q   <= wr_ptr_d;
      fill_ptr_q <= fill_ptr_d;
      rem_q      <= rem_d;
      cnt_q      <= cnt_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    hid_q <= hid_d;
    if (cmd_i.in_load) begin
      act_q  <= fmrq_pkg::action_e'(action_i);
      id_q   <= msg_id_i;
      len_q  <= msg_len_i;
      data_q <= data_word_i;
    end
    if (cmd_i.out_load) begin
      out_kind_q <= cmd_i.out_kind;
      out_id_q   <= '0;
      out_len_q  <= '0;
      out_word_q <= '0;
      case (cmd_i.out_kind)
        fmrq_pkg::KIND_HDR: begin
          out_sts_q  <= fmrq_pkg::ST_OK;
          out_id_q   <= fmrq_pkg::ID_W'(hid_q);
          out_len_q  <= rd_len;
          out_last_q <= rd_len == '0;
        end
        fmrq_pkg::KIND_WORD: begin
          out_sts_q  <= fmrq_pkg::ST_OK;
          out_word_q <= fmrq_pkg::DATA_W'(rd_data_q);
          out_last_q <= cnt_q == LW'(1);
        end
        default: begin
          out_sts_q  <= cmd_i.ack_status;
          out_last_q <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_sts_q;
  assign kind_o      = out_kind_q;
  assign out_id_o    = out_id_q;
  assign out_len_o   = out_len_q;
  assign out_word_o  = out_word_q;
  assign last_o      = out_last_q;

  // owed payload and streaming count never pass the longest message
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= LW'(fmrq_pkg::MAX_PAYLOAD))
    else $error("payload count beyond limit");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LW'(fmrq_pkg::MAX_PAYLOAD))
    else $error("stream count beyond limit");

  // final payload word commits the message
  a_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == fmrq_pkg::OP_PAYLOAD && rem_q == LW'(1)) |=>
      (wr_ptr_q == fill_ptr_q && rem_q == '0))
    else $error("message not committed on last word");

  // a result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");

endmodule

`default_nettype wire

// File: rtl/framed_message_ring_queue.sv
// ----------------------------------------------------------------------------
// framed_message_ring_queue
// Variable length message queue kept as framed words in a ring memory.
// ----------------------------------------------------------------------------
// Usage:
//  - in_i carries requests: put header (id, length), put payload word,
//    get message, flush. A word is taken when valid and ready are high.
//  - out_o carries results. Put, payload and flush give one acknowledge;
//    a get gives one header result and then one result per payload word,
//    last set on the final one. A get on an empty ring gives one
//    acknowledge with the empty status.
//  - One request is handled at a time. A put header passes through one
//    more state, S_HDR_LEN, storing its length word after its result is
//    loaded. A get streams one word per cycle while the receiver is
//    ready, off the single registered read port of the ring memory.
//  - A result waits in an output register, so the next request is taken
//    while the previous result is still unclaimed. When the receiver
//    stalls the sequencer holds, and no result is lost or repeated.
//  - Reset clears the pointers and counters: the ring reads as empty at
//    once; no clearing pass runs over the memory.
// ----------------------------------------------------------------------------
`default_nettype none

module framed_message_ring_queue (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  fmrq_in_if.sink     in_i,
  fmrq_out_if.source  out_o
);

  fmrq_pkg::cmd_t cmd;
  fmrq_pkg::sts_t sts;

  // sequencer
  fmrq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // ring, pointers and result register
  fmrq_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .action_i    (in_i.action),
    .msg_id_i    (in_i.msg_id),
    .msg_len_i   (in_i.msg_len),
    .data_word_i (in_i.data_word),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .status_o    (out_o.status),
    .kind_o      (out_o.kind),
    .out_id_o    (out_o.out_id),
    .out_len_o   (out_o.out_len),
    .out_word_o  (out_o.out_word),
    .last_o      (out_o.last)
  );

endmodule

`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the framed message ring queue. Requests are queued by the
// stimulus process and fed to the request channel by a clocked driver. Each
// accepted request is run through a local copy of the ring, which queues the
// results the block should give. A clocked monitor checks every result word,
// field by field, against the oldest queued one. A directed opening covers
// the special cases. It is followed by three random phases with varying
// back-pressure.
// ----------------------------------------------------------------------------

module tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 40;

  // One request word and one result word, as seen on the channels
  typedef struct {
    fmrq_pkg::action_e                act;
    logic [fmrq_pkg::ID_W-1:0]        id;
    logic [fmrq_pkg::LEN_W-1:0]       len;
    logic [fmrq_pkg::DATA_W-1:0]      data;
  } ring_req_t;

  typedef struct {
    fmrq_pkg::status_e                sts;
    fmrq_pkg::kind_e                  kind;
    logic [fmrq_pkg::ID_W-1:0]        id;
    logic [fmrq_pkg::LEN_W-1:0]       len;
    logic [fmrq_pkg::DATA_W-1:0]      word;
    logic                             last;
  } ring_result_t;

  logic clk;
  logic rst_n;

  fmrq_in_if  req_if ();
  fmrq_out_if rsp_if ();

  framed_message_ring_queue u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  // Requests waiting to be driven, and the word currently on the channel
  ring_req_t    req_backlog[$];
  ring_req_t    live_req;
  // Results the block owes, oldest first
  ring_result_t due_results[$];

  int send_idle_pct;
  int recv_stall_pct;
  int n_queued;
  int n_err;
  int cycle_cnt;

  // Tallies for the closing summary
  int n_accepted, n_msgs_read, n_words_read, n_empty;
  int n_too_long, n_no_room, n_stray, n_flush;

  // Local copy of the ring: memory, pointers and the open put
  logic [fmrq_pkg::WORD_BITS-1:0] mirror_mem [fmrq_pkg::RING_DEPTH];
  logic [fmrq_pkg::PTR_W-1:0]     m_rd   = '0;
  logic [fmrq_pkg::PTR_W-1:0]     m_wr   = '0;
  logic [fmrq_pkg::PTR_W-1:0]     m_fill = '0;
  logic [fmrq_pkg::LEN_W-1:0]     m_owed = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Result bookkeeping and the ring copy
  // --------------------------------------------------------------------------
  function automatic void add_result(fmrq_pkg::status_e sts, fmrq_pkg::kind_e kind,
                                     logic [fmrq_pkg::ID_W-1:0] id,
                                     logic [fmrq_pkg::LEN_W-1:0] len,
                                     logic [fmrq_pkg::DATA_W-1:0] word,
                                     logic last);
    ring_result_t r;
    r.sts  = sts;
    r.kind = kind;
    r.id   = id;
    r.len  = len;
    r.word = word;
    r.last = last;
    due_results.push_back(r);
  endfunction

  task automatic mirror_ring_op(input ring_req_t r);
    logic [fmrq_pkg::PTR_W-1:0]     used_w;
    logic [fmrq_pkg::ID_W-1:0]      hid;
    logic [fmrq_pkg::WORD_BITS-1:0] lenw;
    int                             n;
    n_accepted++;
    case (r.act)
      fmrq_pkg::ACT_PUT_HDR: begin
        // any open put is dropped: it was never committed
        m_owed = '0;
        m_fill = m_wr;
        used_w = m_wr - m_rd;
        if (r.len > fmrq_pkg::MAX_PAYLOAD) begin
          add_result(fmrq_pkg::ST_TOO_LONG, fmrq_pkg::KIND_ACK, '0, '0, '0, 1'b1);
          n_too_long++;
        end else if (fmrq_pkg::RING_DEPTH - int'(used_w) <= int'(r.len) + 2) begin
          // strict room test, so a full ring never reads as empty
          add_result(fmrq_pkg::ST_NO_ROOM, fmrq_pkg::KIND_ACK, '0, '0, '0, 1'b1);
          n_no_room++;
        end else begin
          mirror_mem[m_fill] = r.id;
          m_fill++;
          mirror_mem[m_fill] = fmrq_pkg::WORD_BITS'(r.len);
          m_fill++;
          if (r.len == 0) m_wr = m_fill;
          else m_owed = r.len;
          add_result(fmrq_pkg::ST_OK, fmrq_pkg::KIND_ACK, '0, '0, '0, 1'b1);
        end
      end
      fmrq_pkg::ACT_PUT_WORD: begin
        if (m_owed == 0) begin
          add_result(fmrq_pkg::ST_NO_ROOM, fmrq_pkg::KIND_ACK, '0, '0, '0, 1'b1);
          n_stray++;
        end else begin
          mirror_mem[m_fill] = r.data;
          m_fill++;
          m_owed--;
          if (m_owed == 0) m_wr = m_fill;
          add_result(fmrq_pkg::ST_OK, fmrq_pkg::KIND_ACK, '0, '0, '0, 1'b1);
        end
      end
      fmrq_pkg::ACT_GET: begin
        if (m_rd == m_wr) begin
          add_result(fmrq_pkg::ST_EMPTY, fmrq_pkg::KIND_ACK, '0, '0, '0, 1'b1);
          n_empty++;
        end else begin
          hid = mirror_mem[m_rd];
          m_rd++;
          lenw = mirror_mem[m_rd];
          m_rd++;
          n = (lenw > fmrq_pkg::MAX_PAYLOAD) ? fmrq_pkg::MAX_PAYLOAD : int'(lenw);
          add_result(fmrq_pkg::ST_OK, fmrq_pkg::KIND_HDR, hid,
                     fmrq_pkg::LEN_W'(n), '0, n == 0);
          for (int i = 0; i < n; i++) begin
            add_result(fmrq_pkg::ST_OK, fmrq_pkg::KIND_WORD, '0, '0,
                       mirror_mem[m_rd], i + 1 == n);
            m_rd++;
          end
          n_msgs_read++;
          n_words_read += n;
        end
      end
      default: begin
        // flush: committed messages go, an open put carries on
        m_rd = m_wr;
        add_result(fmrq_pkg::ST_OK, fmrq_pkg::KIND_ACK, '0, '0, '0, 1'b1);
        n_flush++;
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Driver: takes the next request from the backlog whenever the channel is
  // free, idling at random. Prediction runs on the word accepted at this edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) mirror_ring_op(live_req);
      if (!req_if.valid || req_if.ready) begin
        if (req_backlog.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          live_req = req_backlog.pop_front();
          req_if.valid     <= 1'b1;
          req_if.action    <= live_req.act;
          req_if.msg_id    <= live_req.id;
          req_if.msg_len   <= live_req.len;
          req_if.data_word <= live_req.data;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: random back-pressure, and a check of every accepted result word
  // --------------------------------------------------------------------------
  task automatic check_result();
    ring_result_t got;
    ring_result_t want;
    got.sts  = fmrq_pkg::status_e'(rsp_if.status);
    got.kind = fmrq_pkg::kind_e'(rsp_if.kind);
    got.id   = rsp_if.out_id;
    got.len  = rsp_if.out_len;
    got.word = rsp_if.out_word;
    got.last = rsp_if.last;
    if (due_results.size() == 0) begin
      $display("%0t: unexpected result sts=%0d kind=%0d id=%h len=%0d word=%h last=%b",
               $time, got.sts, got.kind, got.id, got.len, got.word, got.last);
      n_err++;
    end else begin
      want = due_results.pop_front();
      if (got.sts !== want.sts || got.kind !== want.kind || got.id !== want.id ||
          got.len !== want.len || got.word !== want.word || got.last !== want.last) begin
        $display("%0t: mismatch expected sts=%0d kind=%0d id=%h len=%0d word=%h last=%b",
                 $time, want.sts, want.kind, want.id, want.len, want.word, want.last);
        $display("%0t:          actual   sts=%0d kind=%0d id=%h len=%0d word=%h last=%b",
                 $time, got.sts, got.kind, got.id, got.len, got.word, got.last);
        n_err++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) check_result();
      rsp_if.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_req(input fmrq_pkg::action_e act,
                           input logic [fmrq_pkg::ID_W-1:0] id,
                           input logic [fmrq_pkg::LEN_W-1:0] len,
                           input logic [fmrq_pkg::DATA_W-1:0] data);
    ring_req_t r;
    r.act  = act;
    r.id   = id;
    r.len  = len;
    r.data = data;
    req_backlog.push_back(r);
    n_queued++;
  endtask

  // Header plus its full payload, random content
  task automatic queue_message(input int len);
    queue_req(fmrq_pkg::ACT_PUT_HDR, $urandom(), fmrq_pkg::LEN_W'(len), $urandom());
    for (int i = 0; i < len; i++)
      queue_req(fmrq_pkg::ACT_PUT_WORD, $urandom(),
                fmrq_pkg::LEN_W'($urandom_range(63, 0)), $urandom());
  endtask

  // Mostly well-formed messages and gets; the rest noise and broken puts
  task automatic queue_random_traffic(input int n_items);
    int target;
    int pick;
    int len;
    int cut;
    target = n_queued + n_items;
    while (n_queued < target) begin
      pick = $urandom_range(99, 0);
      if (pick < 45) begin
        len = ($urandom_range(3, 0) != 0) ? $urandom_range(6, 0) : $urandom_range(32, 7);
        queue_message(len);
      end else if (pick < 70) begin
        queue_req(fmrq_pkg::ACT_GET, $urandom(),
                  fmrq_pkg::LEN_W'($urandom_range(63, 0)), $urandom());
      end else if (pick < 75) begin
        queue_req(fmrq_pkg::ACT_FLUSH, $urandom(),
                  fmrq_pkg::LEN_W'($urandom_range(63, 0)), $urandom());
      end else if (pick < 82) begin
        // rejected header, then the payload that would have followed
        queue_req(fmrq_pkg::ACT_PUT_HDR, $urandom(),
                  fmrq_pkg::LEN_W'($urandom_range(63, 33)), $urandom());
        cut = $urandom_range(2, 0);
        for (int i = 0; i < cut; i++)
          queue_req(fmrq_pkg::ACT_PUT_WORD, $urandom(),
                    fmrq_pkg::LEN_W'($urandom_range(63, 0)), $urandom());
      end else if (pick < 90) begin
        // header with short payload; whatever comes next breaks in
        len = $urandom_range(12, 2);
        cut = $urandom_range(len - 1, 0);
        queue_req(fmrq_pkg::ACT_PUT_HDR, $urandom(), fmrq_pkg::LEN_W'(len), $urandom());
        for (int i = 0; i < cut; i++)
          queue_req(fmrq_pkg::ACT_PUT_WORD, $urandom(),
                    fmrq_pkg::LEN_W'($urandom_range(63, 0)), $urandom());
      end else if (pick < 95) begin
        queue_req(fmrq_pkg::ACT_PUT_WORD, $urandom(),
                  fmrq_pkg::LEN_W'($urandom_range(63, 0)), $urandom());
      end else begin
        queue_req(fmrq_pkg::action_e'($urandom_range(3, 0)), $urandom(),
                  fmrq_pkg::LEN_W'($urandom_range(63, 0)), $urandom());
      end
    end
  endtask

  // Returns at a falling edge once every request is taken and every result in
  task automatic wait_drained();
    @(negedge clk);
    while (req_backlog.size() != 0 || req_if.valid || due_results.size() != 0)
      @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Run guard
  // --------------------------------------------------------------------------
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk) cycle_cnt++;
    $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    rst_n            = 1'b0;
    req_if.valid     = 1'b0;
    req_if.action    = fmrq_pkg::ACT_GET;
    req_if.msg_id    = '0;
    req_if.msg_len   = '0;
    req_if.data_word = '0;
    rsp_if.ready     = 1'b0;
    n_err            = 0;
    n_queued         = 0;
    send_idle_pct    = 18;
    recv_stall_pct   = 45;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening
    queue_req(fmrq_pkg::ACT_GET, $urandom(), 6'd0, $urandom());         // empty ring
    queue_req(fmrq_pkg::ACT_FLUSH, $urandom(), 6'd63, $urandom());      // nothing held
    queue_req(fmrq_pkg::ACT_PUT_WORD, $urandom(), 6'd0, 32'hFFFF_FFFF); // no open put
    queue_req(fmrq_pkg::ACT_PUT_HDR, 32'hFFFF_FFFF, 6'd0, 32'h0);       // empty payload
    queue_req(fmrq_pkg::ACT_GET, $urandom(), 6'd0, $urandom());
    queue_req(fmrq_pkg::ACT_PUT_HDR, 32'h0, 6'd63, $urandom());         // too long, extreme
    queue_req(fmrq_pkg::ACT_PUT_HDR, $urandom(), 6'd33, $urandom());    // too long by one
    queue_req(fmrq_pkg::ACT_PUT_WORD, $urandom(), 6'd0, $urandom());    // after a reject
    queue_req(fmrq_pkg::ACT_PUT_HDR, 32'hA5A5_5A5A, 6'd2, $urandom());
    queue_req(fmrq_pkg::ACT_PUT_WORD, $urandom(), 6'd0, 32'h0);
    queue_req(fmrq_pkg::ACT_GET, $urandom(), 6'd0, $urandom());         // open put unseen
    queue_req(fmrq_pkg::ACT_PUT_WORD, $urandom(), 6'd0, 32'hFFFF_FFFF); // commits
    queue_req(fmrq_pkg::ACT_PUT_HDR, $urandom(), 6'd3, $urandom());
    queue_req(fmrq_pkg::ACT_PUT_WORD, $urandom(), 6'd0, $urandom());
    queue_req(fmrq_pkg::ACT_PUT_HDR, $urandom(), 6'd1, $urandom());     // abandons open put
    queue_req(fmrq_pkg::ACT_PUT_WORD, $urandom(), 6'd0, $urandom());
    queue_req(fmrq_pkg::ACT_PUT_HDR, $urandom(), 6'd2, $urandom());
    queue_req(fmrq_pkg::ACT_PUT_WORD, $urandom(), 6'd0, $urandom());
    queue_req(fmrq_pkg::ACT_FLUSH, $urandom(), 6'd0, $urandom());       // flush mid put
    queue_req(fmrq_pkg::ACT_PUT_WORD, $urandom(), 6'd0, $urandom());    // still commits
    queue_req(fmrq_pkg::ACT_GET, $urandom(), 6'd0, $urandom());
    queue_req(fmrq_pkg::ACT_GET, $urandom(), 6'd0, $urandom());
    queue_req(fmrq_pkg::ACT_GET, $urandom(), 6'd0, $urandom());

    queue_random_traffic(25);
    wait_drained();

    // Receiver mostly ready, sender gappy
    send_idle_pct  = 45;
    recv_stall_pct = 18;
    queue_random_traffic(25);
    wait_drained();

    // No idling on either side
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    queue_random_traffic(25);
    wait_drained();

    // Let any late stray result show up
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Covered %0d requests: %0d messages read with %0d payload words, %0d empty gets.",
             n_accepted, n_msgs_read, n_words_read, n_empty);
    $display("Rejected headers: %0d too long, %0d without room; %0d stray words, %0d flushes.",
             n_too_long, n_no_room, n_stray, n_flush);
    if (n_err == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/fmrq_pkg.sv
rtl/fmrq_in_if.sv
rtl/fmrq_out_if.sv
rtl/fmrq_ctrl.sv
rtl/fmrq_dpath.sv
rtl/framed_message_ring_queue.sv
sim/tb.sv
